// File: rtl/asd_pkg.sv
// Shared types and constants for the audio superframe deframer.
// Depends on nothing; the top and the checker import it.
package asd_pkg;

  localparam int DATA_W         = 8;
  localparam int FRAME_W        = 4;
  localparam int POS_W          = 13;
  localparam int BORDER_BITS    = 12;
  localparam int SUM_W          = POS_W + 2;
  localparam int MAX_FRAMES_DEF = 10;
  localparam int FIVE_FRAMES    = 5;
  localparam int CFG_AW         = 3;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // register index, taken from paddr[2]
  localparam logic REG_FRAMES_MODE = 1'b0;
  localparam logic REG_SF_LENGTH   = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first_byte;
  } byte_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]  out_byte;
    logic [FRAME_W-1:0] frame_index;
    logic               is_crc;
    logic               frame_end;
    logic               superframe_end;
    logic               error;
    logic               last_in_run;
  } res_word_t;

endpackage

// File: rtl/asd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module asd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/aac_superframe_deframer_top.sv
// Top level of the audio superframe deframer (equal error protection).
// Uses asd_pkg and two asd_ram instances (frame borders, CRC bytes).
//
//   channel  | dir | handshake             | word
//   ---------+-----+-----------------------+----------------------------
//   byte     | in  | byte_valid/byte_stall | byte_word_t (byte, first)
//   res      | out | res_valid/res_stall   | res_word_t (byte + tags)
//   config   | in  | APB psel/penable      | frames_mode @0, length @4
//
// A header or CRC byte, or a payload byte inside a frame, keeps RUN. A
// payload byte led by its frame's CRC gives two words out. Closing a
// frame other than the last, and the last CRC byte, pass FETCH and LOAD:
// the next frame's border and CRC come from the RAMs' registered read
// port, and each zero-length frame after it repeats them. Reset is
// synchronous, with no clearing pass. A held result stalls bytes and pushes.
module aac_superframe_deframer_top #(
  parameter int MAX_FRAMES = asd_pkg::MAX_FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  asd_pkg::byte_word_t       byte_word,
  output logic                      res_valid,
  input  logic                      res_stall,
  output asd_pkg::res_word_t        res_word,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [asd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import asd_pkg::*;

  localparam int BA_DEPTH = MAX_FRAMES - 1;
  localparam int BA_W     = $clog2(BA_DEPTH);
  localparam int CA_W     = $clog2(MAX_FRAMES);
  localparam int HDR_FULL = (BORDER_BITS * (MAX_FRAMES - 1) + 7) / 8;
  localparam int HDR_FIVE = (BORDER_BITS * (FIVE_FRAMES - 1) + 7) / 8;

  // sequencer states
  localparam logic [2:0] S_RUN   = 3'd0;  // ready for a byte
  localparam logic [2:0] S_BYTE  = 3'd1;  // CRC sent, payload byte next
  localparam logic [2:0] S_FETCH = 3'd2;  // RAM read of the new frame
  localparam logic [2:0] S_LOAD  = 3'd3;  // read data back, empty check
  localparam logic [2:0] S_LAST  = 3'd4;  // final CRC of the superframe

  // header phase: byte position modulo 3
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

  // configuration
  logic              cfg_mode;
  logic [POS_W-1:0]  cfg_len;

  // control state
  logic [2:0]               state, state_next;
  logic [POS_W-1:0]         pos, pos_next;
  logic [1:0]               phase, phase_next;
  logic [FRAME_W-1:0]       bidx, bidx_next;
  logic [BORDER_BITS-1:0]   prev_border, prev_border_next;
  logic [BORDER_BITS-1:0]   max_gap, max_gap_next;
  logic                     gap_neg, gap_neg_next;
  logic                     failed, failed_next;
  logic [FRAME_W-1:0]       cur_frame, cur_frame_next;
  logic                     pend_valid, pend_valid_next;
  logic                     res_valid_next;

  // datapath registers
  logic [DATA_W-1:0]        prev_byte, prev_byte_next;
  logic [BORDER_BITS-1:0]   cur_start, cur_start_next;
  logic [BORDER_BITS-1:0]   cur_border, cur_border_next;
  logic [DATA_W-1:0]        cur_crc, cur_crc_next;
  res_word_t                pend_word, pend_word_next;
  logic                     pend_ends, pend_ends_next;

  // frame geometry for the selected mode
  logic [FRAME_W-1:0]       n_frames;
  logic [FRAME_W-1:0]       next_frame;
  logic [POS_W-1:0]         hdr_len;
  logic [POS_W-1:0]         pre_len;
  logic                     cur_is_last;
  logic signed [SUM_W-1:0]  len_minus_pre;

  // word fired this cycle, with first_byte applied
  logic                     byte_fire;
  logic                     first;
  logic [POS_W-1:0]         eff_pos;
  logic [1:0]               eff_phase;
  logic [FRAME_W-1:0]       eff_bidx;
  logic [BORDER_BITS-1:0]   eff_prev_border;
  logic [BORDER_BITS-1:0]   eff_max_gap;
  logic                     eff_gap_neg;
  logic                     eff_failed;
  logic [FRAME_W-1:0]       eff_frame;
  logic [POS_W-1:0]         crc_off;
  logic [POS_W-1:0]         rel;
  logic [POS_W:0]           rel_inc;
  logic signed [SUM_W-1:0]  end_s;
  logic                     ends_now;
  logic                     crc_first;
  logic [BORDER_BITS-1:0]   border_bits;
  logic [BORDER_BITS-1:0]   gap;
  logic                     bad;

  // result register handshake
  logic                     res_free;
  logic                     push;
  res_word_t                push_word;

  // byte resolve, shared by RUN and BYTE
  logic                     resolve;
  res_word_t                rb_word;
  logic                     rb_ends;

  // frame load
  logic signed [SUM_W-1:0]  stop_s;
  logic                     load_empty;

  // memory ports
  logic                     bwe;
  logic [BA_W-1:0]          bwaddr;
  logic [BA_W-1:0]          braddr;
  logic [BORDER_BITS-1:0]   brdata;
  logic                     cwe;
  logic [CA_W-1:0]          cwaddr;
  logic [CA_W-1:0]          craddr;
  logic [DATA_W-1:0]        crdata;

  // ---------------------------------------------------------------------
  // Configuration port. Index is paddr[2]; low bits are ignored.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode <= 1'b0;
      cfg_len  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[CFG_AW-1])
        REG_FRAMES_MODE: cfg_mode <= pwdata[0];
        REG_SF_LENGTH:   cfg_len  <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_AW-1])
      REG_FRAMES_MODE: prdata = {31'b0, cfg_mode};
      REG_SF_LENGTH:   prdata = {{(32-POS_W){1'b0}}, cfg_len};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Geometry: frame count, header length, payload start.
  // ---------------------------------------------------------------------
  assign n_frames   = cfg_mode ? FRAME_W'(FIVE_FRAMES) : FRAME_W'(MAX_FRAMES);
  assign hdr_len    = cfg_mode ? POS_W'(HDR_FIVE) : POS_W'(HDR_FULL);
  assign pre_len    = hdr_len + {{(POS_W-FRAME_W){1'b0}}, n_frames};
  assign next_frame = cur_frame + 1'b1;
  assign cur_is_last = (next_frame >= n_frames);
  assign len_minus_pre = $signed({2'b0, cfg_len}) - $signed({2'b0, pre_len});

  // ---------------------------------------------------------------------
  // Handshakes. Bytes enter only in RUN with the result register free.
  // ---------------------------------------------------------------------
  assign res_free   = !res_valid || !res_stall;
  assign byte_stall = !((state == S_RUN) && res_free);
  assign byte_fire  = byte_valid && !byte_stall;

  // a first_byte word restarts parsing before it is looked at
  assign first           = byte_word.first_byte;
  assign eff_pos         = first ? '0 : pos;
  assign eff_phase       = first ? PH_START : phase;
  assign eff_bidx        = first ? '0 : bidx;
  assign eff_prev_border = first ? '0 : prev_border;
  assign eff_max_gap     = first ? '0 : max_gap;
  assign eff_gap_neg     = first ? 1'b0 : gap_neg;
  assign eff_failed      = first ? 1'b0 : failed;
  assign eff_frame       = first ? '0 : cur_frame;

  // header: 12-bit borders straddle bytes in a three-byte pattern
  assign border_bits = (eff_phase == PH_HIGH) ?
                       {prev_byte, byte_word.data_byte[7:4]} :
                       {prev_byte[3:0], byte_word.data_byte};
  assign gap = border_bits - eff_prev_border;

  assign crc_off = eff_pos - hdr_len;

  // payload: relative position against the cached frame window
  assign rel       = eff_pos - pre_len;
  assign rel_inc   = {1'b0, rel} + 1'b1;
  assign end_s     = cur_is_last ? len_minus_pre : $signed({3'b0, cur_border});
  assign ends_now  = $signed({1'b0, rel_inc}) >= end_s;
  assign crc_first = rel <= {{(POS_W-BORDER_BITS){1'b0}}, cur_start};

  // frame load: stop of the frame just read, against its start
  assign stop_s     = cur_is_last ? len_minus_pre : $signed({3'b0, brdata});
  assign load_empty = stop_s <= $signed({3'b0, cur_start});

  // RAM read address tracks the current frame; data arrives in the next cycle
  assign craddr = cur_frame[CA_W-1:0];
  assign braddr = (cur_frame < FRAME_W'(BA_DEPTH)) ? cur_frame[BA_W-1:0] : '0;

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    phase_next       = phase;
    bidx_next        = bidx;
    prev_border_next = prev_border;
    max_gap_next     = max_gap;
    gap_neg_next     = gap_neg;
    failed_next      = failed;
    cur_frame_next   = cur_frame;
    pend_valid_next  = pend_valid;
    prev_byte_next   = prev_byte;
    cur_start_next   = cur_start;
    cur_border_next  = cur_border;
    cur_crc_next     = cur_crc;
    pend_word_next   = pend_word;
    pend_ends_next   = pend_ends;
    push             = 1'b0;
    push_word        = '0;
    resolve          = 1'b0;
    bad              = 1'b0;
    bwe              = 1'b0;
    bwaddr           = eff_bidx[BA_W-1:0];
    cwe              = 1'b0;
    cwaddr           = crc_off[CA_W-1:0];

    rb_word             = '0;
    rb_word.out_byte    = byte_word.data_byte;
    rb_word.frame_index = cur_frame;
    rb_ends             = ends_now;
    if (state == S_BYTE) begin
      rb_word = pend_word;
      rb_ends = pend_ends;
    end

    unique case (state)
      S_RUN: begin
        if (byte_fire) begin
          pos_next         = eff_pos;
          phase_next       = eff_phase;
          bidx_next        = eff_bidx;
          prev_border_next = eff_prev_border;
          max_gap_next     = eff_max_gap;
          gap_neg_next     = eff_gap_neg;
          failed_next      = eff_failed;
          cur_frame_next   = eff_frame;
          if (!eff_failed) begin
            pos_next = (eff_pos == POS_MAX) ? eff_pos : eff_pos + 1'b1;
            if (eff_pos < hdr_len) begin
              prev_byte_next = byte_word.data_byte;
              phase_next     = (eff_phase == PH_LOW) ? PH_START : eff_phase + 1'b1;
              if (eff_phase != PH_START) begin
                bidx_next = eff_bidx + 1'b1;
                if (eff_bidx < n_frames - 1'b1) begin
                  bwe              = 1'b1;
                  prev_border_next = border_bits;
                  if (border_bits < eff_prev_border) begin
                    gap_neg_next = 1'b1;
                  end else if (gap > eff_max_gap) begin
                    max_gap_next = gap;
                  end
                end
              end
              if (eff_pos == hdr_len - 1'b1) begin
                bad = gap_neg_next ||
                      ({1'b0, max_gap_next} >= cfg_len) ||
                      ({1'b0, cfg_len} <
                       ({1'b0, pre_len} + {2'b0, prev_border_next}));
                if (bad) begin
                  failed_next         = 1'b1;
                  push                = 1'b1;
                  push_word.error     = 1'b1;
                  push_word.last_in_run = 1'b1;
                end
              end
            end else if (eff_pos < pre_len) begin
              cwe = 1'b1;
              if (eff_pos == pre_len - 1'b1) begin
                cur_frame_next  = '0;
                cur_start_next  = '0;
                pend_valid_next = 1'b0;
                state_next      = S_FETCH;
              end
            end else if (eff_frame < n_frames) begin
              if (crc_first) begin
                // CRC leads the frame's first payload byte
                push                  = 1'b1;
                push_word.out_byte    = cur_crc;
                push_word.frame_index = cur_frame;
                push_word.is_crc      = 1'b1;
                pend_word_next        = rb_word;
                pend_ends_next        = ends_now;
                state_next            = S_BYTE;
              end else begin
                resolve = 1'b1;
              end
            end
          end
        end
      end
      S_BYTE: begin
        if (res_free) begin
          resolve = 1'b1;
        end
      end
      S_FETCH: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!pend_valid || res_free) begin
          if (pend_valid) begin
            push                  = 1'b1;
            push_word             = pend_word;
            push_word.last_in_run = !load_empty;
          end
          cur_border_next = brdata;
          cur_crc_next    = crdata;
          if (load_empty) begin
            // zero-length frame: its CRC alone closes it
            pend_word_next             = '0;
            pend_word_next.out_byte    = crdata;
            pend_word_next.frame_index = cur_frame;
            pend_word_next.is_crc      = 1'b1;
            pend_word_next.frame_end   = 1'b1;
            pend_valid_next            = 1'b1;
            cur_frame_next             = next_frame;
            cur_start_next             = brdata;
            state_next                 = cur_is_last ? S_LAST : S_FETCH;
          end else begin
            pend_valid_next = 1'b0;
            state_next      = S_RUN;
          end
        end
      end
      S_LAST: begin
        if (res_free) begin
          push                     = 1'b1;
          push_word                = pend_word;
          push_word.superframe_end = 1'b1;
          push_word.last_in_run    = 1'b1;
          pend_valid_next          = 1'b0;
          state_next               = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase

    // payload byte: ends the run, or closes the frame
    if (resolve) begin
      if (!rb_ends) begin
        push                  = 1'b1;
        push_word             = rb_word;
        push_word.last_in_run = 1'b1;
        state_next            = S_RUN;
      end else begin
        cur_frame_next = next_frame;
        cur_start_next = cur_border;
        if (cur_is_last) begin
          push                     = 1'b1;
          push_word                = rb_word;
          push_word.frame_end      = 1'b1;
          push_word.superframe_end = 1'b1;
          push_word.last_in_run    = 1'b1;
          state_next               = S_RUN;
        end else begin
          pend_word_next           = rb_word;
          pend_word_next.frame_end = 1'b1;
          pend_valid_next          = 1'b1;
          state_next               = S_FETCH;
        end
      end
    end
  end

  assign res_valid_next = push || (res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      pos         <= '0;
      phase       <= PH_START;
      bidx        <= '0;
      prev_border <= '0;
      max_gap     <= '0;
      gap_neg     <= 1'b0;
      failed      <= 1'b0;
      cur_frame   <= '0;
      pend_valid  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      pos         <= pos_next;
      phase       <= phase_next;
      bidx        <= bidx_next;
      prev_border <= prev_border_next;
      max_gap     <= max_gap_next;
      gap_neg     <= gap_neg_next;
      failed      <= failed_next;
      cur_frame   <= cur_frame_next;
      pend_valid  <= pend_valid_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prev_byte  <= prev_byte_next;
    cur_start  <= cur_start_next;
    cur_border <= cur_border_next;
    cur_crc    <= cur_crc_next;
    pend_word  <= pend_word_next;
    pend_ends  <= pend_ends_next;
    if (push) begin
      res_word <= push_word;
    end
  end

  // ---------------------------------------------------------------------
  // Stores: frame borders and per-frame CRC bytes.
  // ---------------------------------------------------------------------
  asd_ram #(
    .WIDTH (BORDER_BITS),
    .DEPTH (BA_DEPTH)
  ) u_border_ram (
    .clk   (clk),
    .we    (bwe),
    .waddr (bwaddr),
    .wdata (border_bits),
    .raddr (braddr),
    .rdata (brdata)
  );

  asd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_FRAMES)
  ) u_crc_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (cwaddr),
    .wdata (byte_word.data_byte),
    .raddr (craddr),
    .rdata (crdata)
  );

endmodule

// File: rtl/asd_checker.sv
// Port-level checks for the audio superframe deframer, bound to its top.
// Uses asd_pkg for the word types.
module asd_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_stall,
  input asd_pkg::byte_word_t byte_word,
  input logic                res_valid,
  input logic                res_stall,
  input asd_pkg::res_word_t  res_word
);
  import asd_pkg::*;

  // error word carries no other tags and closes its run
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.error |->
      res_word.out_byte == '0 && res_word.frame_index == '0 &&
      !res_word.is_crc && !res_word.frame_end &&
      !res_word.superframe_end && res_word.last_in_run)
    else $error("error word with stray tags");

  // superframe end falls on a frame end and ends the run
  a_sf_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.superframe_end |->
      res_word.frame_end && res_word.last_in_run && !res_word.error)
    else $error("superframe end without frame end");

  // a leading CRC does not close its run; its payload byte follows in it
  a_crc_lead: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.is_crc && !res_word.frame_end |->
      !res_word.last_in_run && !res_word.superframe_end)
    else $error("leading CRC closes a run");

  // a byte is taken only while the result register can move
  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall |-> !res_valid || !res_stall)
    else $error("byte accepted behind a held result");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("stalled result word changed");

endmodule

bind aac_superframe_deframer_top asd_checker u_asd_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_word  (byte_word),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res_word   (res_word)
);
